[src/degenerate_triangle_filter_macros.svh]
// Assertion macros for the degenerate triangle filter.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DEGENERATE_TRIANGLE_FILTER_MACROS_SVH
`define DEGENERATE_TRIANGLE_FILTER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define DTF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define DTF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dtf_pkg.sv]
// Package for the degenerate triangle filter: widths, payload and control types.
// No dependencies.
package dtf_pkg;

  localparam int COORD_BITS = 16;
  localparam int IDX_W      = 32;
  localparam int THR_W      = 32;

  localparam int EDGE_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int MAG_W    = 2 * COORD_BITS + 1;
  localparam int SQ_LO_W  = MAG_W / 2;
  localparam int SQ_HI_W  = MAG_W - SQ_LO_W;
  localparam int HH_W     = 2 * SQ_HI_W;
  localparam int HL_W     = SQ_HI_W + SQ_LO_W;
  localparam int LL_W     = 2 * SQ_LO_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int ACC_W    = SQ_W + 2;
  localparam int T2_W     = 2 * THR_W;
  localparam int CMP_W    = (ACC_W > T2_W) ? ACC_W : T2_W;
  localparam int N_AXES   = 3;

  typedef struct packed {
    logic [IDX_W-1:0]             vert_a;
    logic [IDX_W-1:0]             vert_b;
    logic [IDX_W-1:0]             vert_c;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx_coord;
    logic signed [COORD_BITS-1:0] cy_coord;
    logic signed [COORD_BITS-1:0] cz_coord;
  } dtf_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] kept_a;
    logic [IDX_W-1:0] kept_b;
    logic [IDX_W-1:0] kept_c;
  } dtf_out_t;

  // Load enables of the two squaring stages.
  typedef struct packed {
    logic pp_en;
    logic sq_en;
  } dtf_sq_ctrl_t;

endpackage

[src/dtf_square.sv]
// Two-stage exact squarer for a cross product magnitude, split into halves.
// Depends on dtf_pkg.
module dtf_square (
  input  logic                        clk_i,
  input  dtf_pkg::dtf_sq_ctrl_t       ctrl_i,
  input  logic [dtf_pkg::MAG_W-1:0]   mag_i,
  output logic [dtf_pkg::SQ_W-1:0]    sq_o
);
  import dtf_pkg::*;

  logic [SQ_HI_W-1:0] hi;
  logic [SQ_LO_W-1:0] lo;
  logic [HH_W-1:0]    hh_d, hh_q;
  logic [HL_W-1:0]    hl_d, hl_q;
  logic [LL_W-1:0]    ll_d, ll_q;
  logic [SQ_W-1:0]    sq_d, sq_q;

  assign hi = mag_i[MAG_W-1:SQ_LO_W];
  assign lo = mag_i[SQ_LO_W-1:0];

  // Partial products; the cross term appears twice, hence the extra shift.
  assign hh_d = HH_W'(hi) * HH_W'(hi);
  assign hl_d = HL_W'(hi) * HL_W'(lo);
  assign ll_d = LL_W'(lo) * LL_W'(lo);

  assign sq_d = (SQ_W'(hh_q) << (2 * SQ_LO_W))
              + (SQ_W'(hl_q) << (SQ_LO_W + 1))
              + SQ_W'(ll_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pp_en) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      ll_q <= ll_d;
    end
    if (ctrl_i.sq_en) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

[src/degenerate_triangle_filter.sv]
// Top level of the degenerate triangle filter: edge, product, squaring and compare pipeline.
// Depends on dtf_pkg, dtf_square and degenerate_triangle_filter_macros.svh.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    in_data_i   (dtf_in_t)
//   out       output     out_valid_o / out_ready_i  out_data_o  (dtf_out_t)
//   cfg       input      cfg_we_i, no wait          cfg_wdata_i (area threshold)
//
// One triangle can be taken in every cycle in which in_ready_o is high. The pipeline
// is seven registers deep, the six arithmetic stages and the output register. Each stage has
// its own valid bit and advances when it is empty or the stage after it advances, so bubbles
// are squeezed out and a stall holds every item in place.
// Reset clears the valid bits and the threshold; there is no clearing pass.
`include "degenerate_triangle_filter_macros.svh"

module degenerate_triangle_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dtf_pkg::dtf_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dtf_pkg::dtf_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [dtf_pkg::THR_W-1:0]   cfg_wdata_i
);
  import dtf_pkg::*;

  // The indices and the duplicate flag travel alongside the arithmetic as a tag.
  typedef struct packed {
    logic             dup;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } tag_t;

  // Configuration. The squared threshold is recomputed every cycle. The user must change the
  // register only while the pipeline is empty (not enforced), so it is settled long before use.
  logic [THR_W-1:0] thr_q;
  logic [T2_W-1:0]  t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      t2_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      t2_q <= T2_W'(thr_q) * T2_W'(thr_q);
    end
  end

  // Stage enables, chained back from the output register.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6, out_en;
  logic out_valid_q;

  assign out_en     = !out_valid_q || out_ready_i;
  assign en6        = !v6_q || out_en;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Stage 1: edge vectors B - A and C - A, and the equal-index check.
  tag_t                     tag1_d, tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic signed [EDGE_W-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;

  always_comb begin
    tag1_d.dup = (in_data_i.vert_a == in_data_i.vert_b)
              || (in_data_i.vert_b == in_data_i.vert_c)
              || (in_data_i.vert_a == in_data_i.vert_c);
    tag1_d.a   = in_data_i.vert_a;
    tag1_d.b   = in_data_i.vert_b;
    tag1_d.c   = in_data_i.vert_c;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      tag1_q <= tag1_d;
      e1x_q  <= EDGE_W'(in_data_i.bx)       - EDGE_W'(in_data_i.ax);
      e1y_q  <= EDGE_W'(in_data_i.by_coord) - EDGE_W'(in_data_i.ay);
      e1z_q  <= EDGE_W'(in_data_i.bz)       - EDGE_W'(in_data_i.az);
      e2x_q  <= EDGE_W'(in_data_i.cx_coord) - EDGE_W'(in_data_i.ax);
      e2y_q  <= EDGE_W'(in_data_i.cy_coord) - EDGE_W'(in_data_i.ay);
      e2z_q  <= EDGE_W'(in_data_i.cz_coord) - EDGE_W'(in_data_i.az);
    end
  end

  // Stage 2: the six signed edge products. Entry 2k minus entry 2k+1 is cross component k.
  logic signed [PROD_W-1:0] prod_q [2*N_AXES];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      tag2_q    <= tag1_q;
      prod_q[0] <= PROD_W'(e1y_q) * PROD_W'(e2z_q);
      prod_q[1] <= PROD_W'(e1z_q) * PROD_W'(e2y_q);
      prod_q[2] <= PROD_W'(e1z_q) * PROD_W'(e2x_q);
      prod_q[3] <= PROD_W'(e1x_q) * PROD_W'(e2z_q);
      prod_q[4] <= PROD_W'(e1x_q) * PROD_W'(e2y_q);
      prod_q[5] <= PROD_W'(e1y_q) * PROD_W'(e2x_q);
    end
  end

  // Stage 3: cross components and their magnitudes. A magnitude is at most twice the
  // largest edge product, so it always fits the narrower unsigned width.
  logic signed [CROSS_W-1:0] cross_val [N_AXES];
  logic [CROSS_W-1:0]        cross_neg [N_AXES];
  logic [MAG_W-1:0]          mag_d [N_AXES];
  logic [MAG_W-1:0]          mag_q [N_AXES];

  always_comb begin
    for (int k = 0; k < N_AXES; k++) begin
      cross_val[k] = CROSS_W'(prod_q[2*k]) - CROSS_W'(prod_q[2*k+1]);
      cross_neg[k] = -cross_val[k];
      mag_d[k]     = cross_val[k][CROSS_W-1] ? cross_neg[k][MAG_W-1:0]
                                             : cross_val[k][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      tag3_q <= tag2_q;
      mag_q  <= mag_d;
    end
  end

  // Stages 4 and 5: one split squarer per cross component.
  dtf_sq_ctrl_t    sq_ctrl;
  logic [SQ_W-1:0] sq [N_AXES];

  assign sq_ctrl.pp_en = en4;
  assign sq_ctrl.sq_en = en5;

  for (genvar g = 0; g < N_AXES; g++) begin : g_sq
    dtf_square u_sq (
      .clk_i  (clk_i),
      .ctrl_i (sq_ctrl),
      .mag_i  (mag_q[g]),
      .sq_o   (sq[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en4) tag4_q <= tag3_q;
    if (en5) tag5_q <= tag4_q;
  end

  // Stage 6: squared magnitude of the cross product, exact.
  logic [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      tag6_q <= tag5_q;
      acc_q  <= ACC_W'(sq[0]) + ACC_W'(sq[1]) + ACC_W'(sq[2]);
    end
  end

  // Output register: a triangle is kept when its indices differ and its cross product's squared
  // length is not below the squared threshold. Dropped triangles leave no result behind.
  logic     below;
  dtf_out_t out_q;

  assign below = CMP_W'(acc_q) < CMP_W'(t2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= v6_q && !tag6_q.dup && !below;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q.kept_a <= tag6_q.a;
      out_q.kept_b <= tag6_q.b;
      out_q.kept_c <= tag6_q.c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A kept triangle never carries two equal indices.
  `DTF_ASSERT_IMP(a_kept_distinct, out_valid_q, (out_q.kept_a != out_q.kept_b) && (out_q.kept_b != out_q.kept_c) && (out_q.kept_a != out_q.kept_c), "kept triangle has equal indices")
  // With a zero threshold every triangle with distinct indices must come out.
  `DTF_ASSERT_NXT(a_zero_thr_keeps, v6_q && out_en && !tag6_q.dup && (t2_q == '0), out_valid_q, "triangle lost with zero threshold")
  // The input side only stalls when the whole pipeline is blocked by the output.
  `DTF_ASSERT_IMP(a_stall_cause, !in_ready_o, out_valid_q && !out_ready_i, "input stalled without output back-pressure")

endmodule

[tb/sv/degenerate_triangle_filter_tb.sv]
// Self-checking testbench for degenerate_triangle_filter: directed and random triangles under
// several area thresholds and idling patterns, each kept-triangle transfer checked in order.
// Depends on dtf_pkg and the filter RTL; needs no files or arguments.
module degenerate_triangle_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtf_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  // Depth quoted at the head of the filter; a dropped triangle can still be in flight this long.
  localparam int PIPE_DEPTH   = 7;
  localparam int SETTLE_LIMIT = 2000;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 118;
  localparam int AREA_W       = 72;
  localparam int COORD_SPAN   = 65535;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  dtf_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  dtf_out_t         out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = '0;

  // Triangles waiting to be offered, and the index triples that must come out, oldest first.
  dtf_in_t  tri_pending[$];
  dtf_out_t kept_fifo[$];

  // Appends at the back of the two queues.
  function automatic void queue_triangle(dtf_in_t t);
    tri_pending.insert(tri_pending.size(), t);
  endfunction

  function automatic void expect_kept(dtf_out_t k);
    kept_fifo.insert(kept_fifo.size(), k);
  endfunction

  // Our own copy of the threshold register; it only changes while the filter is idle.
  logic [THR_W-1:0] thr_shadow = '0;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  logic        in_taken     = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count    = 0;
  int unsigned tri_count    = 0;
  int unsigned kept_count   = 0;
  int unsigned cfg_writes   = 0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  degenerate_triangle_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // Square of one cross component, taken as a magnitude so the 72-bit sum stays exact.
  function automatic logic [AREA_W-1:0] square_mag(longint v);
    logic [AREA_W-1:0] m;
    m = AREA_W'((v < 0) ? -v : v);
    return m * m;
  endfunction

  // A triangle survives when its three indices differ and the squared length of the edge
  // cross product is not below the squared threshold. Equality counts as kept.
  function automatic bit triangle_survives(dtf_in_t t, logic [THR_W-1:0] thr);
    longint            e1x, e1y, e1z, e2x, e2y, e2z;
    logic [AREA_W-1:0] area_sq, thr_wide;
    if (t.vert_a == t.vert_b || t.vert_b == t.vert_c || t.vert_a == t.vert_c) return 1'b0;
    e1x = longint'($signed(t.bx))       - longint'($signed(t.ax));
    e1y = longint'($signed(t.by_coord)) - longint'($signed(t.ay));
    e1z = longint'($signed(t.bz))       - longint'($signed(t.az));
    e2x = longint'($signed(t.cx_coord)) - longint'($signed(t.ax));
    e2y = longint'($signed(t.cy_coord)) - longint'($signed(t.ay));
    e2z = longint'($signed(t.cz_coord)) - longint'($signed(t.az));
    area_sq = square_mag(e1y * e2z - e1z * e2y)
            + square_mag(e1z * e2x - e1x * e2z)
            + square_mag(e1x * e2y - e1y * e2x);
    thr_wide = AREA_W'(thr);
    return !(area_sq < thr_wide * thr_wide);
  endfunction

  function automatic dtf_in_t pack_triangle(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                            logic [IDX_W-1:0] c, int av[3], int bv[3],
                                            int cv[3]);
    return {a, b, c,
            COORD_BITS'(av[0]), COORD_BITS'(av[1]), COORD_BITS'(av[2]),
            COORD_BITS'(bv[0]), COORD_BITS'(bv[1]), COORD_BITS'(bv[2]),
            COORD_BITS'(cv[0]), COORD_BITS'(cv[1]), COORD_BITS'(cv[2])};
  endfunction

  // Random triangle, biased towards the interesting outcomes: shared indices, collinear and
  // coincident vertices, right triangles whose cross product sits just around the threshold,
  // and triangles spanning the corners of the coordinate range. The rest are plain random.
  function automatic dtf_in_t random_triangle(logic [THR_W-1:0] thr);
    int               av[3], bv[3], cv[3];
    int               kind, u, v, w, p, q, tmp;
    longint           lo_p, hi_p, qq;
    logic [IDX_W-1:0] a, b, c;
    kind = $urandom_range(0, 99);
    a = $urandom();
    b = $urandom();
    c = $urandom();
    for (int k = 0; k < 3; k++) begin
      av[k] = int'($urandom_range(0, COORD_SPAN)) - 32768;
      bv[k] = int'($urandom_range(0, COORD_SPAN)) - 32768;
      cv[k] = int'($urandom_range(0, COORD_SPAN)) - 32768;
    end
    if (kind < 8) begin
      case ($urandom_range(0, 3))
        0: b = a;
        1: c = b;
        2: c = a;
        default: begin
          b = a;
          c = a;
        end
      endcase
    end else if (kind < 20) begin
      // Degenerate geometry: C coincides with A or B, or lies on the line through them.
      tmp = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        av[k] = int'($urandom_range(0, 20000)) - 10000;
        bv[k] = int'($urandom_range(0, 20000)) - 10000;
        case (tmp)
          0: cv[k] = av[k];
          1: cv[k] = bv[k];
          default: cv[k] = 2 * bv[k] - av[k];
        endcase
      end
    end else if (kind < 55) begin
      // Legs p and q along two axes give a cross product of exactly p*q on the third.
      lo_p = longint'(thr / COORD_SPAN) + 1;
      if (lo_p > COORD_SPAN) lo_p = COORD_SPAN;
      if (thr == 0) hi_p = 1;
      else if (thr < COORD_SPAN) hi_p = thr;
      else hi_p = COORD_SPAN;
      if (hi_p < lo_p) hi_p = lo_p;
      p = ($urandom_range(0, 3) == 0) ? int'(lo_p)
                                      : int'($urandom_range(32'(lo_p), 32'(hi_p)));
      qq = longint'(thr / p) + longint'($urandom_range(0, 2)) - 1;
      if (qq < 0) qq = 0;
      if (qq > COORD_SPAN) qq = COORD_SPAN;
      q = int'(qq);
      u = $urandom_range(0, 2);
      v = (u + 1 + $urandom_range(0, 1)) % 3;
      w = 3 - u - v;
      av[u] = int'($urandom_range(0, COORD_SPAN - p)) - 32768;
      bv[u] = av[u] + p;
      cv[u] = av[u];
      av[v] = int'($urandom_range(0, COORD_SPAN - q)) - 32768;
      bv[v] = av[v];
      cv[v] = av[v] + q;
      bv[w] = av[w];
      cv[w] = av[w];
      if ($urandom_range(0, 1) == 1) begin
        for (int k = 0; k < 3; k++) begin
          tmp   = bv[k];
          bv[k] = cv[k];
          cv[k] = tmp;
        end
      end
    end else if (kind < 67) begin
      for (int k = 0; k < 3; k++) begin
        av[k] = $urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 255))
                                     : 32767 - int'($urandom_range(0, 255));
        bv[k] = $urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 255))
                                     : 32767 - int'($urandom_range(0, 255));
        cv[k] = $urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 255))
                                     : 32767 - int'($urandom_range(0, 255));
      end
    end
    return pack_triangle(a, b, c, av, bv, cv);
  endfunction

  // Driver: inputs change on the falling edge. A triangle on offer is held until the rising
  // edge that transfers it, after which the next one may follow straight away.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (tri_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_data_i  <= tri_pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: on the rising edge, predict every input transfer and check every output transfer
  // against the oldest outstanding index triple. Also feeds the watchdog.
  always @(posedge clk_i) begin
    dtf_out_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      tri_count++;
      if (triangle_survives(in_data_i, thr_shadow)) begin
        expect_kept(dtf_out_t'({in_data_i.vert_a, in_data_i.vert_b, in_data_i.vert_c}));
        kept_count++;
      end
    end
    if (out_valid_o && out_ready_i) begin
      if (kept_fifo.size() == 0) begin
        flag_mismatch($sformatf("unexpected triangle %h %h %h", out_data_o.kept_a,
                                out_data_o.kept_b, out_data_o.kept_c));
      end else begin
        want = kept_fifo.pop_front();
        if (out_data_o.kept_a !== want.kept_a)
          flag_mismatch($sformatf("kept_a %h, expected %h", out_data_o.kept_a, want.kept_a));
        if (out_data_o.kept_b !== want.kept_b)
          flag_mismatch($sformatf("kept_b %h, expected %h", out_data_o.kept_b, want.kept_b));
        if (out_data_o.kept_c !== want.kept_c)
          flag_mismatch($sformatf("kept_c %h, expected %h", out_data_o.kept_c, want.kept_c));
      end
    end
    quiet_cycles <= ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) ?
                    0 : quiet_cycles + 1;
  end

  // Waits until every queued triangle has been transferred and every kept one has come out,
  // then lets the pipeline empty of dropped triangles too. Leaves the filter idle.
  task automatic settle();
    int waited = 0;
    do @(posedge clk_i); while (tri_pending.size() != 0 || in_valid_i);
    while (kept_fifo.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (kept_fifo.size() != 0) begin
      flag_mismatch($sformatf("%0d kept triangles never came out", kept_fifo.size()));
      kept_fifo.delete();
    end
  endtask

  // Only ever called with the filter idle, so the shadow can follow at once.
  task automatic set_threshold(logic [THR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_shadow = value;
    cfg_writes++;
  endtask

  // One random phase. Halfway through, the sender holds back until every kept triangle has
  // come out, so the filter is seen draining fully and restarting from empty.
  task automatic run_phase(logic [THR_W-1:0] thr, int unsigned gap, int unsigned stall,
                           int n);
    set_threshold(thr);
    send_gap_pct = gap;
    stall_pct    = stall;
    for (int k = 0; k < n; k++) begin
      queue_triangle(random_triangle(thr));
      if (k == n / 2) settle();
    end
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero threshold: only shared indices drop, whatever the geometry.
    set_threshold('0);
    queue_triangle(pack_triangle(32'h0, 32'h1, 32'hFFFF_FFFF, '{-32768, -32768, -32768},
                                 '{32767, 32767, -32768}, '{32767, -32768, 32767}));
    queue_triangle(pack_triangle(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                                 '{32767, 32767, 32767}, '{32767, 32767, 32767},
                                 '{32767, 32767, 32767}));
    queue_triangle(pack_triangle(5, 5, 6, '{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}));
    queue_triangle(pack_triangle(5, 6, 6, '{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}));
    queue_triangle(pack_triangle(6, 5, 6, '{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}));
    queue_triangle(pack_triangle(0, 0, 0, '{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}));
    queue_triangle(pack_triangle(7, 8, 9, '{0, 0, 0}, '{256, 256, 256},
                                 '{512, 512, 512}));
    queue_triangle(pack_triangle(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678,
                                 '{16'h5555, 16'hAAAA, 16'h5555},
                                 '{16'hAAAA, 16'h5555, 16'hAAAA},
                                 '{16'h5555, 16'h5555, 16'hAAAA}));
    queue_triangle(pack_triangle(1, 2, 3, '{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}));
    settle();

    // Threshold 1000: right triangles either side of it, and exactly on it in every plane.
    set_threshold(32'd1000);
    queue_triangle(pack_triangle(7, 8, 9, '{0, 0, 0}, '{256, 256, 256},
                                 '{512, 512, 512}));
    queue_triangle(pack_triangle(10, 11, 12, '{0, 0, 0}, '{25, 0, 0}, '{0, 40, 0}));
    queue_triangle(pack_triangle(13, 14, 15, '{0, 0, 0}, '{27, 0, 0}, '{0, 37, 0}));
    queue_triangle(pack_triangle(16, 17, 18, '{0, 0, 0}, '{7, 0, 0}, '{0, 143, 0}));
    queue_triangle(pack_triangle(19, 20, 21, '{-9, -9, -9}, '{-9, 31, -9},
                                 '{16, -9, -9}));
    queue_triangle(pack_triangle(22, 23, 24, '{0, 0, 0}, '{0, 25, 0}, '{0, 0, 40}));
    queue_triangle(pack_triangle(25, 26, 27, '{0, 0, 0}, '{0, 0, 25}, '{40, 0, 0}));
    queue_triangle(pack_triangle(28, 29, 28, '{-32768, -32768, -32768},
                                 '{32767, 32767, -32768}, '{32767, -32768, 32767}));
    settle();

    // Largest threshold: only triangles spanning most of the coordinate range survive.
    set_threshold(THR_MAX);
    queue_triangle(pack_triangle(30, 31, 32, '{-32768, -32768, -32768},
                                 '{32767, 32767, -32768}, '{32767, -32768, 32767}));
    queue_triangle(pack_triangle(33, 34, 35, '{-32768, -32768, 0},
                                 '{32767, -32768, 0}, '{-32768, 32767, 0}));
    queue_triangle(pack_triangle(36, 37, 38, '{-32768, -32768, -32768},
                                 '{-32768, -32768, -32768}, '{32767, 32767, 32767}));
    queue_triangle(pack_triangle(39, 40, 41, '{32767, 32767, 32767},
                                 '{-32768, -32768, 32767}, '{-32768, 32767, -32768}));
    settle();

    run_phase('0, 0, 0, PHASE_ITEMS);
    run_phase(THR_W'($urandom_range(2, COORD_SPAN)), 48, 0, PHASE_ITEMS);
    run_phase(THR_W'($urandom()), 0, 48, PHASE_ITEMS);
    run_phase(THR_MAX, 37, 37, PHASE_ITEMS);
    run_phase(THR_W'(1), 0, 0, PHASE_ITEMS);
    run_phase(THR_W'($urandom_range(1 << 20, 1 << 28)), 48, 0, PHASE_ITEMS);
    run_phase(THR_W'(COORD_SPAN), 0, 48, PHASE_ITEMS);
    run_phase(THR_W'($urandom()), 37, 37, PHASE_ITEMS);

    $display("Sent %0d triangles across %0d threshold settings and four idling patterns.",
             tri_count, cfg_writes);
    $display("%0d kept, %0d dropped, %0d mismatches.", kept_count, tri_count - kept_count,
             err_count);
    if (err_count == 0) begin
      $display("degenerate_triangle_filter_tb: clean");
    end else begin
      $display("degenerate_triangle_filter_tb: errors");
    end
    $finish;
  end

  // Watchdog: a long run of cycles with no transfer on either side means the filter is stuck.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog: %0d cycles without a transfer", QUIET_LIMIT);
    $display("degenerate_triangle_filter_tb: errors");
    $finish;
  end

endmodule

[degenerate_triangle_filter.f]
+incdir+src
src/dtf_pkg.sv
src/dtf_square.sv
src/degenerate_triangle_filter.sv
tb/sv/degenerate_triangle_filter_tb.sv
